// File: rtl/core/psx_pkg.sv
package psx_pkg;

	// Line store geometry.
	localparam int ROW_WIDTH = 2048;
	localparam int COL_W     = $clog2(ROW_WIDTH);
	localparam int CNT_W     = $clog2(ROW_WIDTH + 1);

	// Height keys are biased so that unsigned order matches signed order.
	localparam int               KEY_W    = 16;
	localparam logic [KEY_W-1:0] KEY_BIAS = 16'h8000;
	localparam logic [3:0]       TOP_BIT  = 4'd15;

	// Configuration register indexes.
	localparam logic REG_MIN_X = 1'b0;
	localparam logic REG_MAX_X = 1'b1;

	// Row summary kept while the row loads and until its profile is sent.
	typedef struct packed {
		logic              mask_seen;
		logic [COL_W-1:0]  first_col;
		logic [COL_W-1:0]  last_col;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} psx_row_sum_t;

endpackage

// File: rtl/core/psx_line_store.sv
module psx_line_store import psx_pkg::*; (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [COL_W-1:0] wr_addr,
	input  logic [KEY_W-1:0] wr_data,
	input  logic             rd_en,
	input  logic [COL_W-1:0] rd_addr,
	output logic [KEY_W-1:0] rd_data
);

	logic [KEY_W-1:0] mem_q [ROW_WIDTH];

	// One write port for pixel loading.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// One registered read port for the median search.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/psx_row_track.sv
module psx_row_track import psx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               px_fire,
	input  logic               in_object,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic               clear,
	output logic               wr_en,
	output logic [COL_W-1:0]   wr_addr,
	output psx_row_sum_t       row_sum
);

	logic [CNT_W-1:0] col_q;
	psx_row_sum_t     sum_q;
	logic             in_range;
	logic             at_start;

	// Pixels past the row width are dropped.
	assign in_range = col_q < CNT_W'(ROW_WIDTH);
	assign wr_en    = px_fire && in_range;
	assign wr_addr  = col_q[COL_W-1:0];
	assign at_start = sum_q.mask_seen &&
		(col_q == (CNT_W'(sum_q.first_col) + CNT_W'(1)));
	assign row_sum  = sum_q;

	// Column counter and mask edge tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			sum_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			sum_q <= '0;
		end else if (wr_en) begin
			col_q <= col_q + CNT_W'(1);
			if (at_start) begin
				sum_q.start_x <= point_x;
				sum_q.start_y <= point_y;
			end
			if (in_object) begin
				if (!sum_q.mask_seen) begin
					sum_q.mask_seen <= 1'b1;
					sum_q.first_col <= wr_addr;
				end
				sum_q.last_col <= wr_addr;
				sum_q.end_x    <= point_x;
				sum_q.end_y    <= point_y;
			end
		end
	end

endmodule

// File: rtl/core/psx_median.sv
module psx_median import psx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [COL_W-1:0] lo,
	input  logic [COL_W-1:0] hi,
	output logic             rd_en,
	output logic [COL_W-1:0] rd_addr,
	input  logic [KEY_W-1:0] rd_data,
	output logic             done,
	output logic             found,
	output logic [KEY_W-1:0] key
);

	logic             busy_q;
	logic             issue_q;
	logic             vld_s1;
	logic             last_s1;
	logic             done_q;
	logic             found_q;
	logic [3:0]       bit_q;
	logic [COL_W-1:0] addr_q;
	logic [COL_W-1:0] lo_q;
	logic [COL_W-1:0] hi_m1_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] nzc_q;
	logic [CNT_W-1:0] k_q;
	logic [KEY_W-1:0] prefix_q;

	logic [KEY_W-1:0] cur_key;
	logic [KEY_W-1:0] hmask;
	logic             nonzero;
	logic             match;
	logic [CNT_W-1:0] cnt_nx;
	logic [CNT_W-1:0] nzc_nx;
	logic [CNT_W-1:0] k_base;
	logic             take;
	logic             first_pass;

	assign rd_en   = issue_q;
	assign rd_addr = addr_q;
	assign done    = done_q;
	assign found   = found_q;
	assign key     = prefix_q;

	// Classify the word that returns from the store against the current prefix.
	always_comb begin
		first_pass = bit_q == TOP_BIT;
		cur_key    = rd_data ^ KEY_BIAS;
		nonzero    = rd_data != '0;
		hmask      = (16'hFFFF << bit_q) << 1;
		match      = nonzero && ((cur_key & hmask) == prefix_q) && !cur_key[bit_q];
		cnt_nx     = cnt_q + CNT_W'(match);
		nzc_nx     = nzc_q + CNT_W'(nonzero);
		k_base     = first_pass ? (nzc_nx >> 1) : k_q;
		take       = k_base >= cnt_nx;
	end

	// One pass over the column span per key bit, most significant first.
	// The first pass also counts nonzero heights to fix the rank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			bit_q    <= '0;
			addr_q   <= '0;
			lo_q     <= '0;
			hi_m1_q  <= '0;
			cnt_q    <= '0;
			nzc_q    <= '0;
			k_q      <= '0;
			prefix_q <= '0;
		end else begin
			done_q  <= 1'b0;
			vld_s1  <= issue_q && !start;
			last_s1 <= issue_q && !start && (addr_q == hi_m1_q);
			if (start) begin
				busy_q   <= 1'b1;
				issue_q  <= 1'b1;
				bit_q    <= TOP_BIT;
				prefix_q <= '0;
				addr_q   <= lo;
				lo_q     <= lo;
				hi_m1_q  <= hi - COL_W'(1);
				cnt_q    <= '0;
				nzc_q    <= '0;
				k_q      <= '0;
			end else begin
				if (issue_q) begin
					addr_q <= addr_q + COL_W'(1);
					if (addr_q == hi_m1_q) begin
						issue_q <= 1'b0;
					end
				end
				if (vld_s1) begin
					cnt_q <= cnt_nx;
					if (first_pass) begin
						nzc_q <= nzc_nx;
					end
					if (last_s1) begin
						cnt_q <= '0;
						if (take) begin
							k_q      <= k_base - cnt_nx;
							prefix_q <= prefix_q | (KEY_W'(1) << bit_q);
						end else begin
							k_q <= k_base;
						end
						if ((first_pass && nzc_nx == '0) || bit_q == 4'd0) begin
							busy_q  <= 1'b0;
							done_q  <= 1'b1;
							found_q <= !(first_pass && nzc_nx == '0);
						end else begin
							bit_q   <= bit_q - 4'd1;
							addr_q  <= lo_q;
							issue_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Reads only come back while a search runs.
	a_vld_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> busy_q)
		else $error("store data returned outside a search");

	// A search that is started is running in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("search did not start");

	// Reads stay inside the column span of the row.
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_addr >= lo_q && rd_addr <= hi_m1_q))
		else $error("store read outside the column span");

endmodule

// File: rtl/core/scanline_profile_extractor.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    in_object, point_x, point_y, point_z, row_number, row_end
// output    out_valid / out_ready  profile_valid, right_distance, left_distance, mid_y,
//                                  median_height, row_tag
// config    cfg_we                 cfg_index, cfg_data
//
// Each pixel's height goes into the line store, up to the row width.
// A row end pixel moves to a check state; a qualified row then gets a median search of
// sixteen passes over the columns strictly inside its object span, on the single store read port.
// A row whose first pass finds no nonzero height stops after that pass.
// Pixels of the next row are taken once the profile sits in the output register.
// Reset clears all control state and sets the belt bounds to their full range.
module scanline_profile_extractor import psx_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               in_object,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] point_z,
	input  logic [10:0]        row_number,
	input  logic               row_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               profile_valid,
	output logic signed [16:0] right_distance,
	output logic signed [16:0] left_distance,
	output logic signed [15:0] mid_y,
	output logic signed [15:0] median_height,
	output logic [10:0]        row_tag,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_CHECK  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_EMIT   = 4'b1000
	} psx_state_t;

	psx_state_t         state_q;
	logic signed [15:0] min_x_q;
	logic signed [15:0] max_x_q;
	logic [10:0]        tag_q;
	logic               ok_q;

	logic               px_fire;
	logic               wr_en;
	logic [COL_W-1:0]   wr_addr;
	psx_row_sum_t       row_sum;
	logic               clear;
	logic               qualified;
	logic               med_start;
	logic [COL_W-1:0]   span_lo;
	logic               rd_en;
	logic [COL_W-1:0]   rd_addr;
	logic [KEY_W-1:0]   rd_data;
	logic               med_done;
	logic               med_found;
	logic [KEY_W-1:0]   med_key;
	logic               emit_go;
	logic signed [16:0] y_sum;

	logic               out_valid_q;
	logic               prof_valid_q;
	logic signed [16:0] right_q;
	logic signed [16:0] left_q;
	logic signed [15:0] mid_y_q;
	logic signed [15:0] median_q;
	logic [10:0]        tag_out_q;

	assign in_ready       = state_q == ST_LOAD;
	assign px_fire        = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign profile_valid  = prof_valid_q;
	assign right_distance = right_q;
	assign left_distance  = left_q;
	assign mid_y          = mid_y_q;
	assign median_height  = median_q;
	assign row_tag        = tag_out_q;

	// Span check: at least two columns between start and end.
	assign qualified = row_sum.mask_seen &&
		((COL_W+2)'(row_sum.first_col) + (COL_W+2)'(3) <= (COL_W+2)'(row_sum.last_col));
	assign span_lo   = row_sum.first_col + COL_W'(1);
	assign med_start = (state_q == ST_CHECK) && qualified;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign clear     = emit_go;
	assign y_sum     = 17'(row_sum.start_y) + 17'(row_sum.end_y);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= -16'sd32768;
			max_x_q <= 16'sd32767;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X: min_x_q <= cfg_data;
				REG_MAX_X: max_x_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Row sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			tag_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (px_fire && row_end) begin
						tag_q   <= row_number;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					ok_q    <= 1'b0;
					state_q <= qualified ? ST_SEARCH : ST_EMIT;
				end
				ST_SEARCH: begin
					if (med_done) begin
						ok_q    <= med_found;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Output register; a zero profile carries only the row tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			prof_valid_q <= 1'b0;
			right_q      <= '0;
			left_q       <= '0;
			mid_y_q      <= '0;
			median_q     <= '0;
			tag_out_q    <= '0;
		end else if (emit_go) begin
			out_valid_q  <= 1'b1;
			prof_valid_q <= ok_q;
			tag_out_q    <= tag_q;
			if (ok_q) begin
				right_q  <= 17'(max_x_q) - 17'(row_sum.start_x);
				left_q   <= 17'(row_sum.end_x) - 17'(min_x_q);
				mid_y_q  <= y_sum[16:1];
				median_q <= med_key ^ KEY_BIAS;
			end else begin
				right_q  <= '0;
				left_q   <= '0;
				mid_y_q  <= '0;
				median_q <= '0;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	psx_row_track u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.px_fire   (px_fire),
		.in_object (in_object),
		.point_x   (point_x),
		.point_y   (point_y),
		.clear     (clear),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.row_sum   (row_sum)
	);

	psx_line_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (point_z),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	psx_median u_median (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (med_start),
		.lo      (span_lo),
		.hi      (row_sum.last_col),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.done    (med_done),
		.found   (med_found),
		.key     (med_key)
	);

	// A found median is one of the nonzero heights.
	a_median_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && profile_valid) |-> (median_height != '0))
		else $error("valid profile with zero median height");

	// A profile that was not found carries zero values.
	a_zero_prof: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !profile_valid) |->
		(right_distance == '0 && left_distance == '0 && mid_y == '0 && median_height == '0))
		else $error("empty profile with nonzero values");

	// No pixel is taken while the store is being searched.
	a_no_load_search: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !in_ready)
		else $error("pixel taken during median search");

endmodule
